### src/mlwt_pkg.sv
// ----------------------------------------------------------------------------
// mlwt_pkg
// shared constants of the lattice walk tracker: register map and stream layout
// ----------------------------------------------------------------------------
`default_nettype none

package mlwt_pkg;

  // configuration register map
  localparam int unsigned CFG_ADDR_BITS = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_X     = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_Y     = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NARROW_CUR_X  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NARROW_CUR_Y  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NARROW_PREV_X = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NARROW_PREV_Y = 3'd5;

  // input stream layout
  localparam int unsigned IN_TDATA_BITS  = 8;
  localparam int unsigned IN_VERTICAL_BIT = 0;
  localparam int unsigned IN_NEW_WALK_BIT = 1;

endpackage : mlwt_pkg

`default_nettype wire

### src/manhattan_lattice_walk_tracker.sv
// ----------------------------------------------------------------------------
// manhattan_lattice_walk_tracker
// follows a walk on the manhattan lattice and reports position, box and flags
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one step per transaction, tdata bit 0 step_vertical, bit 1 new_walk
//   out_* : one result per step (position, target flag, narrow flag, box)
//   cfg_* : plain write port for target and narrow points, write only while idle
// the result of a step is registered and on out_* in the cycle after it fires
// throughput: one step per cycle while out_tready is high; the walk state and
//   the result register are both loaded at the input transaction, so the loop
//   through the saturating step, box and point compares sets the cycle time
// stall: the output register holds its result while out_tready is low; a new
//   step is taken whenever the output register is empty or being drained in
//   the same cycle, so the two sides never wait on each other needlessly
// reset: synchronous on rst_n low; the walk sits at the origin with both
//   directions positive, all configuration registers are zero and the output
//   register is empty
// a restart step (new_walk set) puts the walk back at the origin before moving
// ----------------------------------------------------------------------------
`default_nettype none

module manhattan_lattice_walk_tracker #(
  parameter int unsigned COORD_BITS = 11
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,

  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [mlwt_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [COORD_BITS-1:0]                 cfg_wdata,

  // step stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // bit 0 step_vertical, bit 1 new_walk, rest zero
  input  wire logic [mlwt_pkg::IN_TDATA_BITS-1:0]    in_tdata,

  // result stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // from bit 0: pos_x, pos_y, at_target, narrow_hit,
  // box_min_x, box_max_x, box_min_y, box_max_y, zero fill
  output logic [((6*COORD_BITS+2+7)/8)*8-1:0]        out_tdata
);

  import mlwt_pkg::*;

  localparam int unsigned PAY_BITS = 6 * COORD_BITS + 2;
  localparam int unsigned OUT_BITS = ((PAY_BITS + 7) / 8) * 8;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] STEP_ONE  = COORD_BITS'(1);

  // configuration registers
  logic signed [COORD_BITS-1:0] target_x_r;
  logic signed [COORD_BITS-1:0] target_y_r;
  logic signed [COORD_BITS-1:0] ncur_x_r;
  logic signed [COORD_BITS-1:0] ncur_y_r;
  logic signed [COORD_BITS-1:0] nprev_x_r;
  logic signed [COORD_BITS-1:0] nprev_y_r;

  // walk state
  logic signed [COORD_BITS-1:0] cur_x_r,  cur_x_nxt;
  logic signed [COORD_BITS-1:0] cur_y_r,  cur_y_nxt;
  logic                         hneg_r,   hneg_nxt;
  logic                         vneg_r,   vneg_nxt;
  logic signed [COORD_BITS-1:0] low_x_r,  low_x_nxt;
  logic signed [COORD_BITS-1:0] high_x_r, high_x_nxt;
  logic signed [COORD_BITS-1:0] low_y_r,  low_y_nxt;
  logic signed [COORD_BITS-1:0] high_y_r, high_y_nxt;

  // output register
  logic                         out_valid_r;
  logic [PAY_BITS-1:0]          out_pay_r;
  logic [PAY_BITS-1:0]          out_pay_nxt;

  // step decode
  logic                         in_fire;
  logic                         step_vert;
  logic                         fresh;

  // start point of this step: walk state or origin on a restart
  logic signed [COORD_BITS-1:0] base_x;
  logic signed [COORD_BITS-1:0] base_y;
  logic                         base_hneg;
  logic                         base_vneg;
  logic signed [COORD_BITS-1:0] base_low_x;
  logic signed [COORD_BITS-1:0] base_high_x;
  logic signed [COORD_BITS-1:0] base_low_y;
  logic signed [COORD_BITS-1:0] base_high_y;

  logic                         at_target;
  logic                         prev_near;
  logic                         cur_near;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign step_vert = in_tdata[IN_VERTICAL_BIT];
  assign fresh     = in_tdata[IN_NEW_WALK_BIT];

  // configuration writes, indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r <= '0;
      target_y_r <= '0;
      ncur_x_r   <= '0;
      ncur_y_r   <= '0;
      nprev_x_r  <= '0;
      nprev_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_X:      target_x_r <= cfg_wdata;
        REG_TARGET_Y:      target_y_r <= cfg_wdata;
        REG_NARROW_CUR_X:  ncur_x_r   <= cfg_wdata;
        REG_NARROW_CUR_Y:  ncur_y_r   <= cfg_wdata;
        REG_NARROW_PREV_X: nprev_x_r  <= cfg_wdata;
        REG_NARROW_PREV_Y: nprev_y_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // restart puts everything at the origin before the move
  always_comb begin
    if (fresh) begin
      base_x      = '0;
      base_y      = '0;
      base_hneg   = 1'b0;
      base_vneg   = 1'b0;
      base_low_x  = '0;
      base_high_x = '0;
      base_low_y  = '0;
      base_high_y = '0;
    end else begin
      base_x      = cur_x_r;
      base_y      = cur_y_r;
      base_hneg   = hneg_r;
      base_vneg   = vneg_r;
      base_low_x  = low_x_r;
      base_high_x = high_x_r;
      base_low_y  = low_y_r;
      base_high_y = high_y_r;
    end
  end

  // saturating move along one axis, then flip the other axis' direction
  always_comb begin
    cur_x_nxt = base_x;
    cur_y_nxt = base_y;
    hneg_nxt  = base_hneg;
    vneg_nxt  = base_vneg;
    if (step_vert) begin
      if (base_vneg) begin
        if (base_y != COORD_MIN) cur_y_nxt = base_y - STEP_ONE;
      end else begin
        if (base_y != COORD_MAX) cur_y_nxt = base_y + STEP_ONE;
      end
      hneg_nxt = !base_hneg;
    end else begin
      if (base_hneg) begin
        if (base_x != COORD_MIN) cur_x_nxt = base_x - STEP_ONE;
      end else begin
        if (base_x != COORD_MAX) cur_x_nxt = base_x + STEP_ONE;
      end
      vneg_nxt = !base_vneg;
    end
  end

  // running bounding box
  always_comb begin
    low_x_nxt  = (cur_x_nxt < base_low_x)  ? cur_x_nxt : base_low_x;
    high_x_nxt = (cur_x_nxt > base_high_x) ? cur_x_nxt : base_high_x;
    low_y_nxt  = (cur_y_nxt < base_low_y)  ? cur_y_nxt : base_low_y;
    high_y_nxt = (cur_y_nxt > base_high_y) ? cur_y_nxt : base_high_y;
  end

  assign at_target = (cur_x_nxt == target_x_r) && (cur_y_nxt == target_y_r);

  // previous point of this step is its start point
  mlwt_neighbor #(
    .COORD_BITS (COORD_BITS)
  ) u_prev_near (
    .ax  (base_x),
    .ay  (base_y),
    .bx  (nprev_x_r),
    .by  (nprev_y_r),
    .hit (prev_near)
  );

  mlwt_neighbor #(
    .COORD_BITS (COORD_BITS)
  ) u_cur_near (
    .ax  (cur_x_nxt),
    .ay  (cur_y_nxt),
    .bx  (ncur_x_r),
    .by  (ncur_y_r),
    .hit (cur_near)
  );

  assign out_pay_nxt = {high_y_nxt, low_y_nxt, high_x_nxt, low_x_nxt,
                        prev_near && cur_near, at_target,
                        cur_y_nxt, cur_x_nxt};

  // walk state advances on every accepted step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      hneg_r   <= 1'b0;
      vneg_r   <= 1'b0;
      low_x_r  <= '0;
      high_x_r <= '0;
      low_y_r  <= '0;
      high_y_r <= '0;
    end else if (in_fire) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      hneg_r   <= hneg_nxt;
      vneg_r   <= vneg_nxt;
      low_x_r  <= low_x_nxt;
      high_x_r <= high_x_nxt;
      low_y_r  <= low_y_nxt;
      high_y_r <= high_y_nxt;
    end
  end

  // output register: filled by a step, emptied by a downstream transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pay_r <= out_pay_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'(out_pay_r);

endmodule : manhattan_lattice_walk_tracker

`default_nettype wire

### src/mlwt_neighbor.sv
// ----------------------------------------------------------------------------
// mlwt_neighbor
// flags two lattice points at manhattan distance exactly one
// ----------------------------------------------------------------------------
`default_nettype none

module mlwt_neighbor #(
  parameter int unsigned COORD_BITS = 11
) (
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  output logic                              hit
);

  localparam int unsigned DW = COORD_BITS + 1;

  localparam logic [DW-1:0] ONE     = DW'(1);
  localparam logic [DW-1:0] NEG_ONE = {DW{1'b1}};

  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  logic          dx_zero;
  logic          dy_zero;
  logic          dx_unit;
  logic          dy_unit;

  // differences one bit wider so they never wrap
  assign dx = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
  assign dy = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};

  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign dx_unit = (dx == ONE) || (dx == NEG_ONE);
  assign dy_unit = (dy == ONE) || (dy == NEG_ONE);

  assign hit = (dx_zero && dy_unit) || (dx_unit && dy_zero);

endmodule : mlwt_neighbor

`default_nettype wire
